/* rtl/m3alu_pkg.sv */
// Shared constants, types and helpers for the 3x3 matrix arithmetic unit.
// No dependencies; imported by the channel interfaces and the core.
package m3alu_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  // The data fields are 32 bits, so the element width never exceeds that.
  localparam int DW    = 32;
  localparam int EW    = (WORD_WIDTH > DW) ? DW : WORD_WIDTH;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = PW + 2;
  localparam int DVW   = DW + FRAC_BITS;
  localparam int TOL_W = 31;
  localparam int NELEM = 9;

  typedef enum logic [3:0] {
    OP_WRA   = 4'd0,
    OP_WRB   = 4'd1,
    OP_RDA   = 4'd2,
    OP_CLR   = 4'd3,
    OP_IDENT = 4'd4,
    OP_MUL   = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_DIV   = 4'd8,
    OP_TRANS = 4'd9,
    OP_DET   = 4'd10,
    OP_CMP   = 4'd11
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 sat;
  } sat_res_t;

  // Clamp a wide signed value into the signed element range.
  function automatic sat_res_t sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    sat_res_t r;
    hi = (ACC_W'(1) <<< (EW - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    r.sat = 1'b0;
    if (v > hi) begin
      r.value = DW'(hi);
      r.sat   = 1'b1;
    end else if (v < lo) begin
      r.value = DW'(lo);
      r.sat   = 1'b1;
    end else begin
      r.value = DW'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/m3alu_if.sv */
// Valid/ready channel interfaces for request, result and configuration traffic.
// Depends on m3alu_pkg for the field widths.
interface m3alu_in_if import m3alu_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [3:0]           opcode;
  logic [1:0]           row;
  logic [1:0]           column;
  logic signed [DW-1:0] operand_value;
  modport source (output valid, opcode, row, column, operand_value, input ready);
  modport sink (input valid, opcode, row, column, operand_value, output ready);
endinterface

interface m3alu_out_if import m3alu_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] result_value;
  logic                 equal_flag;
  logic [1:0]           status;
  modport source (output valid, result_value, equal_flag, status, input ready);
  modport sink (input valid, result_value, equal_flag, status, output ready);
endinterface

interface m3alu_cfg_if import m3alu_pkg::*;;
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

/* rtl/matrix3x3_arithmetic_unit_core.sv */
// Top level of the 3x3 Q16.16 matrix arithmetic unit.
// Depends on m3alu_pkg and the channel interfaces in m3alu_if.sv.
//
// One request is taken at a time and gives one result. Element writes, reads,
// clear, identity, transpose and unused opcodes are done on acceptance; add,
// subtract and compare walk the nine elements through one adder; multiply runs
// 27 products through one 32x32 multiplier and accumulator; determinant runs 9
// products the same way; division runs each element through a bit-serial
// divider of 48 steps. The input is ready again once the result has moved into
// the output register.
module matrix3x3_arithmetic_unit_core import m3alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  m3alu_in_if.sink    in_ch,
  m3alu_out_if.source out_ch,
  m3alu_cfg_if.sink   cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_ELEM, S_MPROD, S_MACC, S_MRND, S_COPY, S_DIV, S_DSTORE, S_OUT
  } state_t;

  localparam int DCW = $clog2(DVW);

  state_t                  state_r;
  state_t                  start_state;
  op_t                     op_r;
  logic signed [DW-1:0]    a_r [NELEM];
  logic signed [DW-1:0]    b_r [NELEM];
  logic signed [DW-1:0]    t_r [NELEM];
  logic signed [DW-1:0]    minor_r [3];
  logic signed [DW-1:0]    val_r;
  logic [TOL_W-1:0]        tol_r;
  logic [3:0]              idx_r;
  logic [3:0]              grp_r;
  logic [1:0]              k_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [DW:0]             rem_r;
  logic [DVW-1:0]          num_r;
  logic [DCW-1:0]          dcnt_r;
  logic                    neg_r;
  logic                    sat_r;
  logic                    eq_r;
  logic [1:0]              status_r;
  logic signed [DW-1:0]    res_r;
  logic                    out_valid_r;
  logic signed [DW-1:0]    out_res_r;
  logic                    out_eq_r;
  logic [1:0]              out_status_r;

  // Operand selection for the shared multiplier.
  logic [3:0]           xi, yi;
  logic                 use_minor, term_neg, last_k;
  logic [1:0]           mi;
  logic signed [DW-1:0] mx, my;

  always_comb begin
    logic [1:0] gi;
    logic [3:0] gj;
    gi = (grp_r >= 4'd6) ? 2'd2 : ((grp_r >= 4'd3) ? 2'd1 : 2'd0);
    gj = grp_r - 4'd3 * {2'b0, gi};
    xi = 4'd0;
    yi = 4'd0;
    mi = 2'd0;
    use_minor = 1'b0;
    term_neg = 1'b0;
    last_k = (k_r == 2'd2);
    if (op_r == OP_MUL) begin
      xi = 4'd3 * {2'b0, gi} + {2'b0, k_r};
      yi = 4'd3 * {2'b0, k_r} + gj;
    end else begin
      term_neg = k_r[0];
      unique case (grp_r)
        4'd0: begin
          xi = k_r[0] ? 4'd5 : 4'd4;
          yi = k_r[0] ? 4'd7 : 4'd8;
          last_k = k_r[0];
        end
        4'd1: begin
          xi = k_r[0] ? 4'd5 : 4'd3;
          yi = k_r[0] ? 4'd6 : 4'd8;
          last_k = k_r[0];
        end
        4'd2: begin
          xi = k_r[0] ? 4'd4 : 4'd3;
          yi = k_r[0] ? 4'd6 : 4'd7;
          last_k = k_r[0];
        end
        default: begin
          // Cofactor expansion along row 0 with the stored minors.
          xi = {2'b0, k_r};
          mi = k_r;
          use_minor = 1'b1;
        end
      endcase
    end
    mx = a_r[xi];
    my = use_minor ? minor_r[mi] : (op_r == OP_MUL ? b_r[yi] : a_r[yi]);
  end

  // Rounding to nearest, ties up, then clamp.
  logic signed [ACC_W-1:0] rnd_sum;
  sat_res_t                rnd_res;
  assign rnd_sum = (acc_r + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign rnd_res = sat_word(rnd_sum);

  // Elementwise add/subtract/compare through one adder.
  logic signed [DW:0]    elem_sum;
  logic [DW:0]           elem_mag;
  sat_res_t              elem_res;
  assign elem_sum = (op_r == OP_ADD) ?
                    ({a_r[idx_r][DW-1], a_r[idx_r]} + {b_r[idx_r][DW-1], b_r[idx_r]}) :
                    ({a_r[idx_r][DW-1], a_r[idx_r]} - {b_r[idx_r][DW-1], b_r[idx_r]});
  assign elem_mag = elem_sum[DW] ? (DW+1)'(-elem_sum) : elem_sum;
  assign elem_res = sat_word(ACC_W'(elem_sum));

  // Bit-serial restoring divider on magnitudes.
  logic [DW-1:0] dmag;
  logic [DW:0]   rem_sh;
  logic          dfit;
  assign dmag   = val_r[DW-1] ? DW'(-val_r) : DW'(val_r);
  assign rem_sh = {rem_r[DW-1:0], num_r[DVW-1]};
  assign dfit   = rem_sh >= {1'b0, dmag};

  logic signed [DVW+1:0] quo_s;
  sat_res_t              quo_res;
  assign quo_s   = neg_r ? -$signed({2'b0, num_r}) : $signed({2'b0, num_r});
  assign quo_res = sat_word(ACC_W'(quo_s));

  function automatic logic [DVW-1:0] div_load(input logic signed [DW-1:0] e);
    logic [DW-1:0] m;
    m = e[DW-1] ? DW'(-e) : DW'(e);
    return {m, {FRAC_BITS{1'b0}}};
  endfunction

  logic       in_range;
  logic [3:0] in_idx;
  sat_res_t   wr_res;
  logic       out_free;
  assign in_range = (in_ch.row < 2'd3) && (in_ch.column < 2'd3);
  assign in_idx   = 4'd3 * {2'b0, in_ch.row} + {2'b0, in_ch.column};
  assign wr_res   = sat_word(ACC_W'(in_ch.operand_value));
  assign out_free = !out_valid_r || out_ch.ready;

  // First state of the sequencer for a newly accepted request.
  always_comb begin
    unique case (in_ch.opcode)
      OP_MUL, OP_DET:         start_state = S_MPROD;
      OP_ADD, OP_SUB, OP_CMP: start_state = S_ELEM;
      OP_DIV:                 start_state = (in_ch.operand_value == '0) ? S_OUT : S_DIV;
      default:                start_state = S_OUT;
    endcase
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.equal_flag   = out_eq_r;
  assign out_ch.status       = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_WRA;
      tol_r       <= TOL_W'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < NELEM; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
      end
    end else begin
      if (cfg_ch.valid) tol_r <= cfg_ch.tolerance;
      // In S_OUT the output register is either reloaded or still held.
      if (out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r     <= op_t'(in_ch.opcode);
            val_r    <= in_ch.operand_value;
            sat_r    <= in_range && wr_res.sat &&
                        (in_ch.opcode == OP_WRA || in_ch.opcode == OP_WRB);
            eq_r     <= (in_ch.opcode == OP_CMP);
            status_r <= (in_ch.opcode == OP_DIV && in_ch.operand_value == '0) ?
                        ST_DIVZ : ST_OK;
            res_r    <= (in_ch.opcode == OP_RDA && in_range) ? a_r[in_idx] : '0;
            idx_r    <= '0;
            grp_r    <= '0;
            k_r      <= '0;
            state_r  <= start_state;
            unique case (in_ch.opcode)
              OP_WRA: if (in_range) a_r[in_idx] <= wr_res.value;
              OP_WRB: if (in_range) b_r[in_idx] <= wr_res.value;
              OP_CLR, OP_IDENT: begin
                for (int i = 0; i < NELEM; i++) begin
                  a_r[i] <= (in_ch.opcode == OP_IDENT && (i % 4) == 0) ?
                            (DW'(1) <<< FRAC_BITS) : '0;
                end
              end
              OP_DIV: begin
                if (in_ch.operand_value != '0) begin
                  num_r  <= div_load(a_r[0]);
                  neg_r  <= a_r[0][DW-1] ^ in_ch.operand_value[DW-1];
                  rem_r  <= '0;
                  dcnt_r <= '0;
                end
              end
              OP_TRANS: begin
                for (int i = 0; i < 3; i++) begin
                  for (int j = 0; j < 3; j++) begin
                    a_r[i*3+j] <= a_r[j*3+i];
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_ELEM: begin
          if (op_r == OP_CMP) begin
            if (elem_mag > {2'b0, tol_r}) eq_r <= 1'b0;
          end else begin
            a_r[idx_r] <= elem_res.value;
            if (elem_res.sat) sat_r <= 1'b1;
          end
          idx_r <= idx_r + 4'd1;
          if (idx_r == 4'(NELEM - 1)) state_r <= S_OUT;
        end
        S_MPROD: begin
          prod_r  <= mx * my;
          state_r <= S_MACC;
        end
        S_MACC: begin
          if (term_neg) begin
            acc_r <= (k_r == 2'd0 ? '0 : acc_r) - ACC_W'(prod_r);
          end else begin
            acc_r <= (k_r == 2'd0 ? '0 : acc_r) + ACC_W'(prod_r);
          end
          if (last_k) begin
            state_r <= S_MRND;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_MPROD;
          end
        end
        S_MRND: begin
          if (rnd_res.sat) sat_r <= 1'b1;
          k_r   <= '0;
          grp_r <= grp_r + 4'd1;
          if (op_r == OP_MUL) begin
            t_r[grp_r] <= rnd_res.value;
            state_r    <= (grp_r == 4'(NELEM - 1)) ? S_COPY : S_MPROD;
          end else if (grp_r == 4'd3) begin
            res_r   <= rnd_res.value;
            state_r <= S_OUT;
          end else begin
            minor_r[grp_r[1:0]] <= rnd_res.value;
            state_r             <= S_MPROD;
          end
        end
        S_COPY: begin
          for (int i = 0; i < NELEM; i++) a_r[i] <= t_r[i];
          state_r <= S_OUT;
        end
        S_DIV: begin
          // The dividend shifts out at the top as quotient bits come in.
          rem_r  <= dfit ? (rem_sh - {1'b0, dmag}) : rem_sh;
          num_r  <= {num_r[DVW-2:0], dfit};
          dcnt_r <= dcnt_r + DCW'(1);
          if (dcnt_r == DCW'(DVW - 1)) state_r <= S_DSTORE;
        end
        S_DSTORE: begin
          a_r[idx_r] <= quo_res.value;
          if (quo_res.sat) sat_r <= 1'b1;
          if (idx_r == 4'(NELEM - 1)) begin
            state_r <= S_OUT;
          end else begin
            idx_r   <= idx_r + 4'd1;
            num_r   <= div_load(a_r[idx_r + 4'd1]);
            neg_r   <= a_r[idx_r + 4'd1][DW-1] ^ val_r[DW-1];
            rem_r   <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_res_r    <= res_r;
            out_eq_r     <= eq_r;
            out_status_r <= (sat_r && status_r == ST_OK) ? ST_SAT : status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb_matrix3x3_arithmetic_unit_core.sv */
// Self-checking testbench for the 3x3 Q16.16 matrix arithmetic unit core.
// Depends on m3alu_pkg, the channel interfaces in m3alu_if.sv and the core RTL.
module tb_matrix3x3_arithmetic_unit_core;
  import m3alu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] OP_UNUSED_LO = 4'd12;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 145;

  typedef struct {
    logic signed [31:0] result;
    logic               eq;
    logic [1:0]         status;
  } alu_result_t;

  typedef struct {
    logic [3:0]         op;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] val;
    bit                 known;
    alu_result_t        want;
  } alu_req_t;

  logic clk;
  logic rst_n;

  m3alu_in_if  in_ch();
  m3alu_out_if out_ch();
  m3alu_cfg_if cfg_ch();

  matrix3x3_arithmetic_unit_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the unit's matrices and tolerance register.
  logic signed [31:0] shadow_a [9];
  logic signed [31:0] shadow_b [9];
  logic [TOL_W-1:0]   shadow_tol;

  alu_result_t pending_results[$];
  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;
  bit pressure_req;
  bit pressure_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [95:0] v, inout bit flag);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    hi = 96'sd2147483647;
    lo = -96'sd2147483648;
    if (v > hi) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < lo) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Round to nearest at the fraction point, ties toward plus infinity.
  function automatic logic signed [95:0] round_frac(input logic signed [95:0] s);
    return (s + 96'sd32768) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [95:0] wide_mul(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
    logic signed [95:0] wx;
    logic signed [95:0] wy;
    wx = x;
    wy = y;
    return wx * wy;
  endfunction

  function automatic alu_result_t alu_predict(input alu_req_t rq);
    alu_result_t r;
    bit sat;
    bit inrange;
    int idx;
    logic signed [31:0] t [9];
    logic signed [95:0] acc;
    logic signed [31:0] m0, m1, m2;
    longint dq;
    longint diff;
    r.result = '0;
    r.eq = 1'b0;
    r.status = ST_OK;
    sat = 1'b0;
    inrange = (rq.row < 2'd3) && (rq.col < 2'd3);
    idx = rq.row * 3 + rq.col;
    case (rq.op)
      OP_WRA: begin
        if (inrange) shadow_a[idx] = rq.val;
      end
      OP_WRB: begin
        if (inrange) shadow_b[idx] = rq.val;
      end
      OP_RDA: begin
        if (inrange) r.result = shadow_a[idx];
      end
      OP_CLR, OP_IDENT: begin
        for (int i = 0; i < 9; i++)
          shadow_a[i] = (rq.op == OP_IDENT && i % 4 == 0) ? 32'sh00010000 : 32'sh0;
      end
      OP_MUL: begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            acc = '0;
            for (int k = 0; k < 3; k++)
              acc += wide_mul(shadow_a[i*3+k], shadow_b[k*3+j]);
            t[i*3+j] = clamp32(round_frac(acc), sat);
          end
        for (int i = 0; i < 9; i++) shadow_a[i] = t[i];
      end
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 9; i++) begin
          acc = shadow_a[i];
          if (rq.op == OP_ADD) acc += 96'(shadow_b[i]);
          else acc -= 96'(shadow_b[i]);
          shadow_a[i] = clamp32(acc, sat);
        end
      end
      OP_DIV: begin
        if (rq.val == 0) begin
          r.status = ST_DIVZ;
        end else begin
          for (int i = 0; i < 9; i++) begin
            dq = (longint'(shadow_a[i]) * 65536) / longint'(rq.val);
            shadow_a[i] = clamp32(96'(dq), sat);
          end
        end
      end
      OP_TRANS: begin
        for (int i = 0; i < 9; i++) t[i] = shadow_a[i];
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            shadow_a[i*3+j] = t[j*3+i];
      end
      OP_DET: begin
        m0 = clamp32(round_frac(wide_mul(shadow_a[4], shadow_a[8])
                                - wide_mul(shadow_a[5], shadow_a[7])), sat);
        m1 = clamp32(round_frac(wide_mul(shadow_a[3], shadow_a[8])
                                - wide_mul(shadow_a[5], shadow_a[6])), sat);
        m2 = clamp32(round_frac(wide_mul(shadow_a[3], shadow_a[7])
                                - wide_mul(shadow_a[4], shadow_a[6])), sat);
        acc = wide_mul(shadow_a[0], m0) - wide_mul(shadow_a[1], m1)
              + wide_mul(shadow_a[2], m2);
        r.result = clamp32(round_frac(acc), sat);
      end
      OP_CMP: begin
        r.eq = 1'b1;
        for (int i = 0; i < 9; i++) begin
          diff = longint'(shadow_a[i]) - longint'(shadow_b[i]);
          if (diff < 0) diff = -diff;
          if (diff > longint'(shadow_tol)) r.eq = 1'b0;
        end
      end
      default: ;
    endcase
    if (sat && r.status == ST_OK) r.status = ST_SAT;
    return r;
  endfunction

  function automatic alu_req_t mk_req(input logic [3:0] op, input int row, input int col,
                                      input logic signed [31:0] val, input bit known,
                                      input logic signed [31:0] res, input logic eq,
                                      input logic [1:0] st);
    alu_req_t rq;
    rq.op = op;
    rq.row = row[1:0];
    rq.col = col[1:0];
    rq.val = val;
    rq.known = known;
    rq.want.result = res;
    rq.want.eq = eq;
    rq.want.status = st;
    return rq;
  endfunction

  function automatic logic signed [31:0] rand_value();
    if ($urandom_range(0, 1) == 0)
      return 32'($urandom_range(0, 32'h0006ffff)) - 32'sh00038000;
    return 32'($urandom);
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    rq.known = 1'b0;
    rq.row = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    rq.col = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    rq.val = rand_value();
    if (pick < 30) rq.op = OP_WRA;
    else if (pick < 50) rq.op = OP_WRB;
    else if (pick < 58) rq.op = OP_RDA;
    else if (pick < 60) rq.op = OP_CLR;
    else if (pick < 62) rq.op = OP_IDENT;
    else if (pick < 68) rq.op = OP_MUL;
    else if (pick < 74) rq.op = OP_ADD;
    else if (pick < 80) rq.op = OP_SUB;
    else if (pick < 84) rq.op = OP_DIV;
    else if (pick < 88) rq.op = OP_TRANS;
    else if (pick < 93) rq.op = OP_DET;
    else if (pick < 98) rq.op = OP_CMP;
    else rq.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (rq.op == OP_DIV && $urandom_range(0, 6) == 0) rq.val = '0;
    return rq;
  endfunction

  // Offer one request, with a random gap first, and predict it once accepted.
  task automatic send_req(input alu_req_t rq);
    alu_result_t r;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= rq.op;
    in_ch.row           <= rq.row;
    in_ch.column        <= rq.col;
    in_ch.operand_value <= rq.val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = alu_predict(rq);
    pending_results.push_back(rq.known ? rq.want : r);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] tol);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.tolerance <= tol;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    shadow_tol = tol;
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the unit.
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    alu_result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: value %h", out_ch.result_value);
      end else begin
        w = pending_results.pop_front();
        if (out_ch.result_value !== w.result || out_ch.equal_flag !== w.eq ||
            out_ch.status !== w.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h eq %b status %0d, got %h eq %b status %0d",
                     w.result, w.eq, w.status, out_ch.result_value, out_ch.equal_flag,
                     out_ch.status);
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    static int quiet = 0;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("matrix3x3_arithmetic_unit_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    alu_req_t directed[$];
    logic [TOL_W-1:0] tol_set [3];
    mismatches = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pressure_req = 1'b0;
    pressure_done = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_WRA;
    in_ch.row <= '0;
    in_ch.column <= '0;
    in_ch.operand_value <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.tolerance <= '0;
    for (int i = 0; i < 9; i++) begin
      shadow_a[i] = '0;
      shadow_b[i] = '0;
    end
    shadow_tol = 31'd1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_req(OP_RDA, 0, 0, 0, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_DET, 0, 0, 0, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_CMP, 0, 0, 0, 1, 0, 1, ST_OK));
    directed.push_back(mk_req(OP_DIV, 0, 0, 0, 1, 0, 0, ST_DIVZ));
    directed.push_back(mk_req(OP_WRA, 0, 0, 32'sh7fffffff, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_WRA, 2, 2, 32'sh80000000, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_RDA, 2, 2, 0, 1, 32'sh80000000, 0, ST_OK));
    directed.push_back(mk_req(OP_RDA, 3, 0, 0, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_WRA, 1, 3, 5, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_RDA, 0, 0, 0, 1, 32'sh7fffffff, 0, ST_OK));
    directed.push_back(mk_req(OP_WRB, 0, 0, 32'sh7fffffff, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_ADD, 0, 0, 0, 1, 0, 0, ST_SAT));
    directed.push_back(mk_req(OP_SUB, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_IDENT, 0, 0, 0, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_WRB, 0, 1, 32'sh00018000, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_WRB, 1, 0, -32'sh00020000, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_MUL, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_TRANS, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_DET, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_DIV, 0, 0, 32'sh00030000, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_CMP, 0, 0, 0, 0, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_UNUSED_LO, 1, 1, 32'sh12345678, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_UNUSED_HI, 2, 2, -1, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_CLR, 0, 0, 0, 1, 0, 0, ST_OK));
    directed.push_back(mk_req(OP_RDA, 1, 1, 0, 1, 0, 0, ST_OK));
    foreach (directed[i]) send_req(directed[i]);
    in_ch.valid <= 1'b0;
    wait_drained();

    tol_set[0] = '0;
    tol_set[1] = 31'h7fffffff;
    tol_set[2] = 31'($urandom_range(0, 32'h0003ffff));
    for (int ph = 0; ph < 3; ph++) begin
      write_tolerance(tol_set[ph]);
      tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 81 : 0;
      rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 32 : 0;
      if (ph == 2) pressure_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_req(rand_req());
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    repeat (500) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("matrix3x3_arithmetic_unit_core regression: pass");
    end else begin
      $display("matrix3x3_arithmetic_unit_core regression: fail");
    end
    $finish;
  end

endmodule
